>>> rtl/core/sppm_pkg.sv
// Shared types and constants for the sprite pixel priority mux.
// Used by sppm_cell, sppm_mux and sprite_pixel_priority_mux_unit; no dependencies.
package sppm_pkg;

    localparam int SLOT_W     = 3;
    localparam int CFG_ADDR_W = 2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_SHOW_SPRITES      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SHOW_SPRITES_LEFT = 2'd1;

    localparam int ATTR_PRI_BIT  = 5;
    localparam int ATTR_FLIP_BIT = 6;

    // One request as it travels down the slot chain.
    typedef struct packed {
        logic              op;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        sprite_x;
        logic [1:0]        palette;
        logic              priority_bg;
        logic [7:0]        plane_low;
        logic [7:0]        plane_high;
        logic              step;
        logic [1:0]        bg_value;
        logic [1:0]        bg_palette;
    } item_t;

    // Winning sprite pixel so far; value zero means none yet.
    typedef struct packed {
        logic [1:0] value;
        logic [1:0] palette;
        logic       priority_bg;
        logic       slot_zero;
    } win_t;

    function automatic logic [7:0] mirror8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7 - i];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/sprite_pixel_priority_mux_unit.sv
// Sprite pixel priority mux: a chain of SPRITE_SLOTS slot cells feeding an output mux.
// Each request is registered in every slot cell of the chain in turn, then in the output mux.
// Throughput: one request per cycle; a stalled result holds the whole chain in place.
// Load requests give no result; each pixel request gives exactly one.
// Reset (aresetn low, synchronous) clears all slots, mask bits and valid flags.
// Depends on sppm_pkg, sppm_cell and sppm_mux.
module sprite_pixel_priority_mux_unit #(
    parameter int SPRITE_SLOTS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // config write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sppm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic                            cfg_data,
    // input requests
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [2:0] slot, [10:3] sprite_x, [18:11] sprite_attr, [26:19] pattern_low,
    // [34:27] pattern_high, [42:35] pixel_x, [44:43] bg_value, [46:45] bg_palette
    input  logic [47:0]                     s_tdata,
    input  logic                            s_tuser,   // [0] op
    // results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata    // [4:0] colour_index, [5] sprite_zero_hit
);

    logic show_sprites_reg;
    logic show_left_reg;
    logic advance;
    logic [7:0] attr;
    logic [7:0] pixel_x;
    sppm_pkg::item_t entry_item;
    sppm_pkg::win_t  entry_win;

    logic            valid_chain [0:SPRITE_SLOTS];
    sppm_pkg::item_t item_chain  [0:SPRITE_SLOTS];
    sppm_pkg::win_t  win_chain   [0:SPRITE_SLOTS];

    logic [4:0] colour_index;
    logic       sprite_zero_hit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            show_sprites_reg <= 1'b0;
            show_left_reg    <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                sppm_pkg::REG_SHOW_SPRITES:      show_sprites_reg <= cfg_data;
                sppm_pkg::REG_SHOW_SPRITES_LEFT: show_left_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    assign attr    = s_tdata[18:11];
    assign pixel_x = s_tdata[42:35];

    always_comb begin
        entry_item.op          = s_tuser;
        entry_item.slot        = s_tdata[2:0];
        entry_item.sprite_x    = s_tdata[10:3];
        entry_item.palette     = attr[1:0];
        entry_item.priority_bg = attr[sppm_pkg::ATTR_PRI_BIT];
        // put the leftmost pixel in bit 0 unless the sprite is flipped
        entry_item.plane_low   = attr[sppm_pkg::ATTR_FLIP_BIT] ? s_tdata[26:19]
                                                               : sppm_pkg::mirror8(s_tdata[26:19]);
        entry_item.plane_high  = attr[sppm_pkg::ATTR_FLIP_BIT] ? s_tdata[34:27]
                                                               : sppm_pkg::mirror8(s_tdata[34:27]);
        entry_item.step        = show_sprites_reg && !((pixel_x < 8'd8) && !show_left_reg);
        entry_item.bg_value    = s_tdata[44:43];
        entry_item.bg_palette  = s_tdata[46:45];
    end

    assign entry_win = '0;

    assign valid_chain[0] = s_tvalid;
    assign item_chain[0]  = entry_item;
    assign win_chain[0]   = entry_win;

    for (genvar g = 0; g < SPRITE_SLOTS; g++) begin : g_cell
        sppm_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (valid_chain[g]),
            .in_item   (item_chain[g]),
            .in_win    (win_chain[g]),
            .out_valid (valid_chain[g+1]),
            .out_item  (item_chain[g+1]),
            .out_win   (win_chain[g+1])
        );
    end

    sppm_mux u_mux (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .advance             (advance),
        .in_valid            (valid_chain[SPRITE_SLOTS]),
        .in_item             (item_chain[SPRITE_SLOTS]),
        .in_win              (win_chain[SPRITE_SLOTS]),
        .out_valid           (m_tvalid),
        .out_colour_index    (colour_index),
        .out_sprite_zero_hit (sprite_zero_hit)
    );

    assign m_tdata = {2'b00, sprite_zero_hit, colour_index};

    // a load request leaving the chain must not produce a result
    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && valid_chain[SPRITE_SLOTS] &&
         item_chain[SPRITE_SLOTS].op == sppm_pkg::OP_LOAD) |=> !m_tvalid)
        else $error("load request produced a result");

    // a pixel with sprites hidden can never report a slot-zero hit
    a_hidden_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && valid_chain[SPRITE_SLOTS] &&
         item_chain[SPRITE_SLOTS].op == sppm_pkg::OP_PIXEL &&
         !item_chain[SPRITE_SLOTS].step) |=> !m_tdata[5])
        else $error("slot-zero hit with sprites hidden");

    // a hit needs an opaque pixel on top
    a_hit_opaque: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[5]) |-> (m_tdata[1:0] != 2'd0))
        else $error("slot-zero hit on a transparent pixel");

endmodule

>>> rtl/core/sppm_cell.sv
// One sprite slot of the chain: holds the slot state and passes each request on.
// Depends on sppm_pkg.
module sppm_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic            in_valid,
    input  sppm_pkg::item_t in_item,
    input  sppm_pkg::win_t  in_win,
    output logic            out_valid,
    output sppm_pkg::item_t out_item,
    output sppm_pkg::win_t  out_win
);

    logic [7:0]      countdown_reg;
    logic [1:0]      palette_reg;
    logic            priority_reg;
    logic [7:0]      plane_low_reg;
    logic [7:0]      plane_high_reg;
    logic            valid_reg;
    sppm_pkg::item_t item_reg;
    sppm_pkg::win_t  win_reg;

    logic           load_hit;
    logic           pixel_step;
    logic [1:0]     pix_value;
    sppm_pkg::win_t win_next;

    assign load_hit   = in_valid && (in_item.op == sppm_pkg::OP_LOAD) &&
                        (32'(in_item.slot) == CELL_IDX);
    assign pixel_step = in_valid && (in_item.op == sppm_pkg::OP_PIXEL) && in_item.step;
    assign pix_value  = {plane_high_reg[0], plane_low_reg[0]};

    always_comb begin
        win_next = in_win;
        if (pixel_step && (countdown_reg == 8'd0) && (pix_value != 2'd0) &&
            (in_win.value == 2'd0)) begin
            win_next.value       = pix_value;
            win_next.palette     = palette_reg;
            win_next.priority_bg = priority_reg;
            win_next.slot_zero   = (CELL_IDX == 0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            countdown_reg  <= '0;
            palette_reg    <= '0;
            priority_reg   <= 1'b0;
            plane_low_reg  <= '0;
            plane_high_reg <= '0;
        end else if (advance) begin
            if (load_hit) begin
                countdown_reg  <= in_item.sprite_x;
                palette_reg    <= in_item.palette;
                priority_reg   <= in_item.priority_bg;
                plane_low_reg  <= in_item.plane_low;
                plane_high_reg <= in_item.plane_high;
            end else if (pixel_step) begin
                if (countdown_reg != 8'd0) begin
                    countdown_reg <= countdown_reg - 8'd1;
                end else begin
                    // shift out the leftmost pixel, zeros fill behind
                    plane_low_reg  <= {1'b0, plane_low_reg[7:1]};
                    plane_high_reg <= {1'b0, plane_high_reg[7:1]};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            item_reg <= in_item;
            win_reg  <= win_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_win   = win_reg;

endmodule

>>> rtl/core/sppm_mux.sv
// Final sprite/background priority mux and output register.
// Depends on sppm_pkg.
module sppm_mux (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic            in_valid,
    input  sppm_pkg::item_t in_item,
    input  sppm_pkg::win_t  in_win,
    output logic            out_valid,
    output logic [4:0]      out_colour_index,
    output logic            out_sprite_zero_hit
);

    logic       valid_reg;
    logic [4:0] colour_reg;
    logic       hit_reg;
    logic [4:0] colour_next;
    logic       hit_next;
    logic [4:0] sprite_colour;
    logic [4:0] bg_colour;
    logic       sp_opaque;
    logic       bg_opaque;

    assign sprite_colour = {1'b1, in_win.palette, in_win.value};
    assign bg_colour     = {1'b0, in_item.bg_palette, in_item.bg_value};
    assign sp_opaque     = (in_win.value != 2'd0);
    assign bg_opaque     = (in_item.bg_value != 2'd0);

    always_comb begin
        colour_next = 5'd0;
        hit_next    = 1'b0;
        if (sp_opaque && bg_opaque) begin
            colour_next = in_win.priority_bg ? bg_colour : sprite_colour;
            hit_next    = in_win.slot_zero;
        end else if (sp_opaque) begin
            colour_next = sprite_colour;
        end else if (bg_opaque) begin
            colour_next = bg_colour;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            // load requests end here with no result
            valid_reg <= in_valid && (in_item.op == sppm_pkg::OP_PIXEL);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            colour_reg <= colour_next;
            hit_reg    <= hit_next;
        end
    end

    assign out_valid           = valid_reg;
    assign out_colour_index    = colour_reg;
    assign out_sprite_zero_hit = hit_reg;

endmodule

>>> dv/sprite_pixel_priority_mux_unit_tb.sv
// Self-checking testbench for sprite_pixel_priority_mux_unit: slot loads, pixel mixing,
// mask bits and random stream stalls, predicted by a cycle-free model held in the bench.
// Depends on sppm_pkg and the unit RTL.
module sprite_pixel_priority_mux_unit_tb;

    localparam int SPRITE_SLOTS  = 8;
    localparam int SETTLE_CYCLES = 4 * (SPRITE_SLOTS + 1);
    localparam int RANDOM_ITEMS  = 1700;

    typedef struct packed {
        logic        op;
        logic [2:0]  slot;
        logic [7:0]  sprite_x;
        logic [7:0]  sprite_attr;
        logic [7:0]  pattern_low;
        logic [7:0]  pattern_high;
        logic [7:0]  pixel_x;
        logic [1:0]  bg_value;
        logic [1:0]  bg_palette;
    } request_t;

    typedef struct packed {
        logic [4:0] colour_index;
        logic       sprite_zero_hit;
    } pixel_result_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [sppm_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic        cfg_data  = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;

    // Mirror of the block state
    logic       mask_show;
    logic       mask_show_left;
    logic [7:0] slot_count [SPRITE_SLOTS];
    logic [1:0] slot_pal   [SPRITE_SLOTS];
    logic       slot_behind[SPRITE_SLOTS];
    logic [7:0] slot_lo    [SPRITE_SLOTS];
    logic [7:0] slot_hi    [SPRITE_SLOTS];

    pixel_result_t colour_due_q[$];
    pixel_result_t colour_want;

    int  mismatch_count  = 0;
    int  results_checked = 0;
    int  loads_sent      = 0;
    int  pixels_sent     = 0;
    int  mask_writes     = 0;
    int  ready_hold      = 0;
    bit  stall_on        = 1'b0;
    bit  idle_on         = 1'b0;

    sprite_pixel_priority_mux_unit #(
        .SPRITE_SLOTS(SPRITE_SLOTS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int pause_cycles();
        if ($urandom_range(0, 11) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] reverse_pattern(input logic [7:0] b);
        return {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]};
    endfunction

    function automatic request_t random_request();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return request_t'(raw[$bits(request_t)-1:0]);
    endfunction

    function automatic request_t load_req(input logic [2:0] slot, input logic [7:0] x,
                                          input logic [7:0] attr, input logic [7:0] lo,
                                          input logic [7:0] hi);
        request_t r;
        r              = random_request();
        r.op           = sppm_pkg::OP_LOAD;
        r.slot         = slot;
        r.sprite_x     = x;
        r.sprite_attr  = attr;
        r.pattern_low  = lo;
        r.pattern_high = hi;
        return r;
    endfunction

    function automatic request_t pixel_req(input logic [7:0] px, input logic [1:0] bgv,
                                           input logic [1:0] bgp);
        request_t r;
        r            = random_request();
        r.op         = sppm_pkg::OP_PIXEL;
        r.pixel_x    = px;
        r.bg_value   = bgv;
        r.bg_palette = bgp;
        return r;
    endfunction

    // Update the mirrored slots for one accepted request; queue the pixel it yields.
    task automatic apply_request(input request_t r);
        logic [1:0]    v;
        logic [1:0]    spr_value;
        logic [1:0]    spr_pal;
        logic          spr_behind;
        logic          spr_zero;
        pixel_result_t res;
        int            i;
        spr_value  = 2'd0;
        spr_pal    = 2'd0;
        spr_behind = 1'b0;
        spr_zero   = 1'b0;
        if (r.op == sppm_pkg::OP_LOAD) begin
            slot_count[r.slot]  = r.sprite_x;
            slot_pal[r.slot]    = r.sprite_attr[1:0];
            slot_behind[r.slot] = r.sprite_attr[sppm_pkg::ATTR_PRI_BIT];
            slot_lo[r.slot] = r.sprite_attr[sppm_pkg::ATTR_FLIP_BIT]
                              ? r.pattern_low : reverse_pattern(r.pattern_low);
            slot_hi[r.slot] = r.sprite_attr[sppm_pkg::ATTR_FLIP_BIT]
                              ? r.pattern_high : reverse_pattern(r.pattern_high);
            loads_sent++;
        end else begin
            if (mask_show && !(r.pixel_x < 8 && !mask_show_left)) begin
                for (i = 0; i < SPRITE_SLOTS; i++) begin
                    if (slot_count[i] != 8'd0) begin
                        slot_count[i] = slot_count[i] - 8'd1;
                    end else begin
                        v = {slot_hi[i][0], slot_lo[i][0]};
                        slot_lo[i] = slot_lo[i] >> 1;
                        slot_hi[i] = slot_hi[i] >> 1;
                        if (v != 2'd0 && spr_value == 2'd0) begin
                            spr_value  = v;
                            spr_pal    = slot_pal[i];
                            spr_behind = slot_behind[i];
                            spr_zero   = (i == 0);
                        end
                    end
                end
            end
            res.sprite_zero_hit = 1'b0;
            if (spr_value != 2'd0 && (r.bg_value == 2'd0 || !spr_behind)) begin
                res.colour_index = {1'b1, spr_pal, spr_value};
            end else if (r.bg_value != 2'd0) begin
                // Background palettes 0..3
                res.colour_index = {1'b0, r.bg_palette, r.bg_value};
            end else begin
                res.colour_index = 5'd0;
            end
            if (spr_value != 2'd0 && r.bg_value != 2'd0) begin
                res.sprite_zero_hit = spr_zero;
            end
            colour_due_q.push_back(res);
            pixels_sent++;
        end
    endtask

    task automatic send_request(input request_t r);
        int gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? pause_cycles() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {1'b0, r.bg_palette, r.bg_value, r.pixel_x, r.pattern_high,
                     r.pattern_low, r.sprite_attr, r.sprite_x, r.slot};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        apply_request(r);
    endtask

    // Drop valid after the last request of a burst.
    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (colour_due_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mask(input logic [sppm_pkg::CFG_ADDR_W-1:0] addr, input logic value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= value;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        if (addr == sppm_pkg::REG_SHOW_SPRITES) begin
            mask_show = value;
        end else if (addr == sppm_pkg::REG_SHOW_SPRITES_LEFT) begin
            mask_show_left = value;
        end
        mask_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Result checker: the handshake seen at the falling edge completes at the next rise.
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (colour_due_q.size() == 0) begin
                $display("%0t: pixel result %h with none outstanding", $realtime, m_tdata);
                mismatch_count++;
            end else begin
                colour_want = colour_due_q.pop_front();
                if (m_tdata[4:0] !== colour_want.colour_index) begin
                    $display("%0t: colour_index expected %0d actual %0d", $realtime,
                             colour_want.colour_index, m_tdata[4:0]);
                    mismatch_count++;
                end
                if (m_tdata[5] !== colour_want.sprite_zero_hit) begin
                    $display("%0t: sprite_zero_hit expected %0b actual %0b", $realtime,
                             colour_want.sprite_zero_hit, m_tdata[5]);
                    mismatch_count++;
                end
                results_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_tready   <= 1'b0;
        end else if (stall_on && $urandom_range(0, 3) == 0) begin
            ready_hold <= pause_cycles() - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Sprites off after reset: only background reaches the output.
    task automatic test_background_only();
        send_request(pixel_req(8'd0, 2'd0, 2'd0));
        send_request(pixel_req(8'd255, 2'd3, 2'd3));
        send_request(pixel_req(8'd7, 2'd1, 2'd2));
        send_request(pixel_req(8'd128, 2'd0, 2'd3));
        end_burst();
    endtask

    // Countdown, flip, priority, lowest-slot win and emptied shift registers.
    task automatic test_sprite_priority();
        write_mask(sppm_pkg::REG_SHOW_SPRITES, 1'b1);
        write_mask(sppm_pkg::REG_SHOW_SPRITES_LEFT, 1'b1);
        send_request(load_req(3'd0, 8'd0, 8'h00, 8'hF0, 8'h0F));
        send_request(load_req(3'd1, 8'd1, 8'h63, 8'hAA, 8'h55));
        send_request(load_req(3'd7, 8'd255, 8'hFF, 8'hFF, 8'hFF));
        for (int p = 0; p < 9; p++) begin
            send_request(pixel_req(8'(p), (p % 2 == 0) ? 2'd0 : 2'd3, 2'(p)));
        end
        end_burst();
    endtask

    // Left-column masking and global sprite disable.
    task automatic test_hidden_sprites();
        write_mask(sppm_pkg::REG_SHOW_SPRITES_LEFT, 1'b0);
        send_request(load_req(3'd0, 8'd0, 8'h20, 8'hFF, 8'hFF));
        send_request(pixel_req(8'd7, 2'd2, 2'd1));
        send_request(pixel_req(8'd0, 2'd0, 2'd0));
        send_request(pixel_req(8'd8, 2'd1, 2'd2));
        send_request(pixel_req(8'd255, 2'd0, 2'd1));
        end_burst();
        write_mask(sppm_pkg::REG_SHOW_SPRITES, 1'b0);
        send_request(pixel_req(8'd100, 2'd3, 2'd2));
        end_burst();
    endtask

    task automatic random_scanline();
        int         n_loads;
        int         n_pixels;
        logic [7:0] px;
        logic [7:0] x;
        n_loads  = $urandom_range(0, SPRITE_SLOTS);
        n_pixels = ($urandom_range(0, 9) == 0) ? 256 : $urandom_range(16, 48);
        px       = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        for (int k = 0; k < n_loads; k++) begin
            x = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 31));
            send_request(load_req(3'($urandom()), x, 8'($urandom()), 8'($urandom()),
                                  8'($urandom())));
        end
        for (int k = 0; k < n_pixels; k++) begin
            send_request(pixel_req(px, 2'($urandom()), 2'($urandom())));
            px = px + 8'd1;
        end
    endtask

    // Scanline-shaped traffic with random content, mixed with noise, over mask settings.
    task automatic test_random_scanlines();
        int  target;
        int  start;
        bit  paused;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_mask(sppm_pkg::REG_SHOW_SPRITES, 1'b1);
                    write_mask(sppm_pkg::REG_SHOW_SPRITES_LEFT, 1'b1);
                end
                1: begin
                    write_mask(sppm_pkg::REG_SHOW_SPRITES_LEFT, 1'b0);
                end
                2: begin
                    write_mask(sppm_pkg::REG_SHOW_SPRITES, 1'b0);
                    write_mask(sppm_pkg::REG_SHOW_SPRITES_LEFT, 1'b1);
                end
                3: begin
                    write_mask(sppm_pkg::REG_SHOW_SPRITES, 1'b1);
                end
                4: begin
                    write_mask(sppm_pkg::REG_SHOW_SPRITES, 1'b0);
                    write_mask(sppm_pkg::REG_SHOW_SPRITES_LEFT, 1'b0);
                end
                default: begin
                    write_mask(sppm_pkg::REG_SHOW_SPRITES, 1'b1);
                end
            endcase
            // Every third phase runs with no gaps or stalls at all
            idle_on  = (phase % 3 != 2);
            stall_on <= (phase % 3 != 2);
            start    = loads_sent + pixels_sent;
            target   = RANDOM_ITEMS / 6;
            paused   = 1'b0;
            while (loads_sent + pixels_sent - start < target) begin
                if ($urandom_range(0, 7) == 0) begin
                    repeat (12) send_request(random_request());
                end else begin
                    random_scanline();
                end
                if (!paused && loads_sent + pixels_sent - start > target / 2) begin
                    // Hold off until the pipeline has emptied
                    end_burst();
                    wait_drained();
                    paused = 1'b1;
                end
            end
            end_burst();
        end
    endtask

    initial begin
        mask_show      = 1'b0;
        mask_show_left = 1'b0;
        for (int i = 0; i < SPRITE_SLOTS; i++) begin
            slot_count[i]  = '0;
            slot_pal[i]    = '0;
            slot_behind[i] = 1'b0;
            slot_lo[i]     = '0;
            slot_hi[i]     = '0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_background_only();
        idle_on  = 1'b1;
        stall_on <= 1'b1;
        test_sprite_priority();
        test_hidden_sprites();
        test_random_scanlines();

        wait_drained();
        $display("Run covered %0d slot loads and %0d pixels under %0d mask writes;",
                 loads_sent, pixels_sent, mask_writes);
        $display("%0d pixel results compared with random gaps and output stalls.",
                 results_checked);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/sppm_pkg.sv
rtl/core/sppm_cell.sv
rtl/core/sppm_mux.sv
rtl/core/sprite_pixel_priority_mux_unit.sv
dv/sprite_pixel_priority_mux_unit_tb.sv
